@@ hw/rtl/dcs_pkg.sv @@
`default_nettype none
package dcs_pkg;

  localparam int VAL_W = 32;
  localparam int CUM_W = 31;
  localparam int TOL_W = 25;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  localparam logic [CUM_W-1:0] CUM_MAX = '1;
  localparam logic [TOL_W-1:0] TOL_RESET = 25'd167;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FINALIZE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_SUM   = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_READY = 2'd3;

  // what one cell hands to the next one down the row
  typedef struct packed {
    logic             le;
    logic             gt;
    logic [VAL_W-1:0] val;
    logic [CUM_W-1:0] cum;
  } link_t;

  typedef struct packed {
    logic ld_en;
    logic smp_en;
    logic fin;
  } ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/discrete_cdf_sampler.sv @@
`default_nettype none
// load, clear, empty finalize, refused draw: answered in S_EVAL, then the registered result; busy until then
// finalize and draw: S_EVAL, S_GRP, S_RED, S_RESP, then the registered result strobe; no new item while busy
// the row of cells compares every entry in parallel; a two-level registered or-tree
// then gathers the selected entry; the receiver cannot stall
// synchronous active-low reset empties the table, clears ready, sets tolerance to 167
module discrete_cdf_sampler #(
  parameter int MAX_ENTRIES = 64,
  parameter int PROB_FRAC_BITS = 24
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire [dcs_pkg::MODE_W-1:0]   in_mode,
  input  wire [dcs_pkg::VAL_W-1:0]    in_entry_value,
  input  wire [PROB_FRAC_BITS:0]      in_entry_probability,
  input  wire [PROB_FRAC_BITS-1:0]    in_uniform_fraction,
  output logic                        out_valid,
  output logic [dcs_pkg::VAL_W-1:0]   out_drawn_value,
  output logic [dcs_pkg::STAT_W-1:0]  out_status,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [dcs_pkg::TOL_W-1:0]    cfg_sum_tolerance
);

  localparam int PFB = PROB_FRAC_BITS;
  localparam int VAL_W = dcs_pkg::VAL_W;
  localparam int CUM_W = dcs_pkg::CUM_W;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int GS = 8;
  localparam int NG = (MAX_ENTRIES + GS - 1) / GS;
  localparam int DW = ((CUM_W > PFB + 1) ? CUM_W : PFB + 1) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_GRP  = 5'b00100,
    S_RED  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         ready_r, ready_nxt;
  logic [dcs_pkg::TOL_W-1:0]    tol_r;
  logic [dcs_pkg::MODE_W-1:0]   mode_r;
  logic [VAL_W-1:0]             val_r;
  logic [PFB:0]                 prob_r;
  logic [PFB-1:0]               frac_r;
  logic                         out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]             out_val_r, out_val_nxt;
  logic [dcs_pkg::STAT_W-1:0]   out_stat_r, out_stat_nxt;

  dcs_pkg::ctl_t  ctl;
  dcs_pkg::link_t head;
  dcs_pkg::link_t lnk [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_sel;

  logic [VAL_W-1:0] grp_val_r [NG];
  logic [CUM_W-1:0] grp_cum_r [NG];
  logic [VAL_W-1:0] grp_val_nxt [NG];
  logic [CUM_W-1:0] grp_cum_nxt [NG];
  logic [VAL_W-1:0] red_val_r, red_val_nxt;
  logic [CUM_W-1:0] red_cum_r, red_cum_nxt;

  logic          accept;
  logic          full;
  logic [DW-1:0] total;
  logic [DW-1:0] one;
  logic [DW-1:0] sum_gap;

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign full      = count_r >= CNT_W'(MAX_ENTRIES);

  assign head.le  = 1'b1;
  assign head.gt  = 1'b0;
  assign head.val = '0;
  assign head.cum = '0;

  always_comb begin
    ctl.fin    = mode_r == dcs_pkg::MODE_FINALIZE;
    ctl.ld_en  = (state_r == S_EVAL) && (mode_r == dcs_pkg::MODE_LOAD) && !full;
    ctl.smp_en = (state_r == S_EVAL) && (count_r != '0) &&
                 ((mode_r == dcs_pkg::MODE_FINALIZE) ||
                  ((mode_r == dcs_pkg::MODE_DRAW) && ready_r));
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      dcs_cell #(.IDX(i), .CNT_W(CNT_W), .PFB(PFB)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .count    (count_r),
        .new_val  (val_r),
        .new_prob (prob_r),
        .frac     (frac_r),
        .prev     (head),
        .nxt_link (lnk[i]),
        .sel      (cell_sel[i])
      );
    end else begin : g_rest
      dcs_cell #(.IDX(i), .CNT_W(CNT_W), .PFB(PFB)) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .count    (count_r),
        .new_val  (val_r),
        .new_prob (prob_r),
        .frac     (frac_r),
        .prev     (lnk[i-1]),
        .nxt_link (lnk[i]),
        .sel      (cell_sel[i])
      );
    end
  end

  // one-hot select gathered in groups of eight, then across groups
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_val_nxt[g] = '0;
      grp_cum_nxt[g] = '0;
      for (int k = 0; k < GS; k++) begin
        if (g * GS + k < MAX_ENTRIES) begin
          if (cell_sel[g * GS + k]) begin
            grp_val_nxt[g] = grp_val_nxt[g] | lnk[g * GS + k].val;
            grp_cum_nxt[g] = grp_cum_nxt[g] | lnk[g * GS + k].cum;
          end
        end
      end
    end
    red_val_nxt = '0;
    red_cum_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      red_val_nxt = red_val_nxt | grp_val_r[g];
      red_cum_nxt = red_cum_nxt | grp_cum_r[g];
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NG; g++) begin
      grp_val_r[g] <= grp_val_nxt[g];
      grp_cum_r[g] <= grp_cum_nxt[g];
    end
    red_val_r <= red_val_nxt;
    red_cum_r <= red_cum_nxt;
  end

  always_comb begin
    total   = DW'(red_cum_r);
    one     = DW'(1) << PFB;
    sum_gap = (total > one) ? (total - one) : (one - total);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ready_nxt     = ready_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    out_stat_nxt  = out_stat_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        out_val_nxt  = '0;
        out_stat_nxt = dcs_pkg::ST_OK;
        state_nxt    = S_IDLE;
        unique case (mode_r)
          dcs_pkg::MODE_LOAD: begin
            out_valid_nxt = 1'b1;
            if (full) begin
              out_stat_nxt = dcs_pkg::ST_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              ready_nxt = 1'b0;
            end
          end
          dcs_pkg::MODE_FINALIZE: begin
            if (count_r == '0) begin
              ready_nxt     = 1'b0;
              out_valid_nxt = 1'b1;
              out_stat_nxt  = dcs_pkg::ST_BAD_SUM;
            end else begin
              state_nxt = S_GRP;
            end
          end
          dcs_pkg::MODE_DRAW: begin
            if (!ready_r || count_r == '0) begin
              out_valid_nxt = 1'b1;
              out_stat_nxt  = dcs_pkg::ST_NOT_READY;
            end else begin
              state_nxt = S_GRP;
            end
          end
          default: begin
            count_nxt     = '0;
            ready_nxt     = 1'b0;
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      S_GRP: begin
        state_nxt = S_RED;
      end
      S_RED: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (mode_r == dcs_pkg::MODE_FINALIZE) begin
          out_val_nxt = '0;
          if (sum_gap <= DW'(tol_r)) begin
            ready_nxt    = 1'b1;
            out_stat_nxt = dcs_pkg::ST_OK;
          end else begin
            ready_nxt    = 1'b0;
            out_stat_nxt = dcs_pkg::ST_BAD_SUM;
          end
        end else begin
          out_val_nxt  = red_val_r;
          out_stat_nxt = dcs_pkg::ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ready_r     <= 1'b0;
      tol_r       <= dcs_pkg::TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_sum_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      val_r  <= in_entry_value;
      prob_r <= in_entry_probability;
      frac_r <= in_uniform_fraction;
    end
    out_val_r  <= out_val_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_val_r;
  assign out_status      = out_stat_r;

`ifndef NO_ASSERTIONS
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GRP |-> $onehot(cell_sel))
    else $error("cell select not one-hot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_ready_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> count_r != '0)
    else $error("table ready while empty");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result beat while still working");

  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EVAL)
    else $error("accepted item not evaluated");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/dcs_cell.sv @@
`default_nettype none
module dcs_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 7,
  parameter int PFB = 24
) (
  input  wire                       clk,
  input  wire dcs_pkg::ctl_t        ctl,
  input  wire [CNT_W-1:0]           count,
  input  wire [dcs_pkg::VAL_W-1:0]  new_val,
  input  wire [PFB:0]               new_prob,
  input  wire [PFB-1:0]             frac,
  input  wire dcs_pkg::link_t       prev,
  output dcs_pkg::link_t            nxt_link,
  output logic                      sel
);

  localparam int CUM_W = dcs_pkg::CUM_W;
  localparam int PROB_W = PFB + 1;
  localparam int SUM_W = ((CUM_W > PROB_W) ? CUM_W : PROB_W) + 1;
  localparam int CMP_W = (CUM_W > PFB) ? CUM_W : PFB;

  logic [dcs_pkg::VAL_W-1:0] val_r;
  logic [CUM_W-1:0]          cum_r;
  logic                      sel_r;

  logic             valid;
  logic             is_last;
  logic             le;
  logic             gt;
  logic [SUM_W-1:0] sum;
  logic [CUM_W-1:0] cum_sat;
  logic             sel_nxt;

  always_comb begin
    valid   = CNT_W'(IDX) < count;
    is_last = count == CNT_W'(IDX + 1);
    le      = valid && (val_r <= new_val);
    gt      = valid && (CMP_W'(frac) < CMP_W'(cum_r));
    sum     = SUM_W'(prev.cum) + SUM_W'(new_prob);
    cum_sat = (sum > SUM_W'(dcs_pkg::CUM_MAX)) ? dcs_pkg::CUM_MAX : sum[CUM_W-1:0];
    // finalize picks the last entry, a draw the first sum above the fraction, else the last entry
    if (ctl.fin) begin
      sel_nxt = is_last;
    end else begin
      sel_nxt = (gt && !prev.gt) || (is_last && !gt);
    end
  end

  always_ff @(posedge clk) begin
    // entries at or below the new value stay, the rest move one place down
    if (ctl.ld_en && !le) begin
      val_r <= prev.le ? new_val : prev.val;
      cum_r <= cum_sat;
    end
    if (ctl.smp_en) begin
      sel_r <= sel_nxt;
    end
  end

  assign nxt_link.le  = le;
  assign nxt_link.gt  = gt;
  assign nxt_link.val = val_r;
  assign nxt_link.cum = cum_r;
  assign sel = sel_r;

endmodule
`default_nettype wire
